// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSLC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sslc assertion failed");
`define SSLC_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("sslc forbidden condition seen");
`else
`define SSLC_ASSERT(lbl, clk, rstn, prop)
`define SSLC_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: src/sslc_pkg.sv
// ---------------------------------------------------------------------------
// sslc_pkg
// Types, constants and helpers of the spline segment leap cost block.
// ---------------------------------------------------------------------------
package sslc_pkg;

    localparam int MaxDimsDef = 8;
    localparam int PosW       = 32;
    localparam int TauW       = 24;
    localparam int CostW      = 64;
    localparam int AddrW      = 3;

    // register index (paddr[AddrW-1:2])
    localparam logic RegOptLastVel = 1'b0;

    localparam logic [6:0] DivLastStep  = 7'd127;
    localparam logic [6:0] SqrtLastStep = 7'd63;

    typedef struct packed {
        logic [CostW-1:0] sd;
        logic [CostW-1:0] sv;
        logic [TauW-1:0]  tau;
        logic             ls;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL, F_RND, F_SQ, F_ACC
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE, B_CUBE1, B_CUBE2, B_DIVA, B_SQA, B_DIVB, B_SQB, B_SUM, B_SQR, B_OUT
    } back_state_t;

    function automatic logic [CostW-1:0] sat_add(input logic [CostW-1:0] a,
                                                 input logic [CostW-1:0] b);
        logic [CostW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CostW] ? {CostW{1'b1}} : s[CostW-1:0];
    endfunction

endpackage

// File: src/sslc_front.sv
// ---------------------------------------------------------------------------
// sslc_front
// Takes one coordinate per request, forms D^2 and V^2, keeps the square sums
// and hands a closed segment to the job queue.
// ---------------------------------------------------------------------------
module sslc_front #(
    parameter int MAX_DIMS = sslc_pkg::MaxDimsDef
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         keep_end_vel,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [31:0]           s_start_pos,
    input  logic signed [31:0]           s_end_pos,
    input  logic signed [31:0]           s_start_vel,
    input  logic signed [31:0]           s_end_vel,
    input  logic [sslc_pkg::TauW-1:0]    s_seg_time,
    input  logic                         s_last_coord,
    input  logic                         s_last_segment,
    output logic                         push_valid,
    input  logic                         push_ready,
    output sslc_pkg::job_t               push_job
);

    localparam int CW = $clog2(MAX_DIMS + 1);

    sslc_pkg::front_state_t state_reg, state_next;

    logic signed [31:0] x0_reg, x1_reg, v0_reg, v1_reg;
    logic [23:0]        tau_reg;
    logic               lc_reg, ls_reg;
    logic signed [57:0] prod_reg;
    logic signed [32:0] dx_reg;
    logic [32:0]        vmag_reg;
    logic [41:0]        d16_reg;
    logic [63:0]        dsq_reg, vsq_reg;
    logic [63:0]        sd_reg, sv_reg;
    logic [CW-1:0]      cnt_reg;

    logic               take, acc_en, close_fire;
    logic signed [32:0] vsum, vd;
    logic signed [24:0] tau_s;
    logic signed [58:0] d33;
    logic [58:0]        mag, rnd;
    logic [65:0]        vprod;
    logic [63:0]        sd_new, sv_new;
    logic [CW-1:0]      cnt_inc;
    logic               close;

    assign vsum    = {v0_reg[31], v0_reg} + {v1_reg[31], v1_reg};
    assign vd      = {v1_reg[31], v1_reg} - {v0_reg[31], v0_reg};
    assign tau_s   = $signed({1'b0, tau_reg});
    assign d33     = $signed({{9{dx_reg[32]}}, dx_reg, 17'b0}) - {prod_reg[57], prod_reg};
    assign mag     = d33[58] ? 59'(-d33) : 59'(d33);
    assign rnd     = mag + 59'd65536;
    assign vprod   = vmag_reg * vmag_reg;
    assign sd_new  = sslc_pkg::sat_add(sd_reg, dsq_reg);
    assign sv_new  = sslc_pkg::sat_add(sv_reg, vsq_reg);
    assign cnt_inc = cnt_reg + CW'(1);
    assign close   = lc_reg || (cnt_inc == CW'(MAX_DIMS));

    assign push_job = '{sd: sd_new, sv: sv_new, tau: tau_reg, ls: ls_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sslc_pkg::F_IDLE: if (s_valid) state_next = sslc_pkg::F_MUL;
            sslc_pkg::F_MUL:  state_next = sslc_pkg::F_RND;
            sslc_pkg::F_RND:  state_next = sslc_pkg::F_SQ;
            sslc_pkg::F_SQ:   state_next = sslc_pkg::F_ACC;
            sslc_pkg::F_ACC:  if (!close || push_ready) state_next = sslc_pkg::F_IDLE;
            default:          state_next = sslc_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        push_valid = 1'b0;
        acc_en     = 1'b0;
        close_fire = 1'b0;
        unique case (state_reg)
            sslc_pkg::F_IDLE: s_ready = 1'b1;
            sslc_pkg::F_ACC: begin
                push_valid = close;
                acc_en     = !close;
                close_fire = close && push_ready;
            end
            default: ;
        endcase
    end

    assign take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sslc_pkg::F_IDLE;
            sd_reg    <= '0;
            sv_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (acc_en) begin
                sd_reg  <= sd_new;
                sv_reg  <= sv_new;
                cnt_reg <= cnt_inc;
            end else if (close_fire) begin
                sd_reg  <= '0;
                sv_reg  <= '0;
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            x0_reg  <= s_start_pos;
            x1_reg  <= s_end_pos;
            v0_reg  <= s_start_vel;
            v1_reg  <= (s_last_segment && !keep_end_vel) ? 32'sd0 : s_end_vel;
            tau_reg <= s_seg_time;
            lc_reg  <= s_last_coord;
            ls_reg  <= s_last_segment;
        end
        if (state_reg == sslc_pkg::F_MUL) begin
            prod_reg <= tau_s * vsum;
            dx_reg   <= {x1_reg[31], x1_reg} - {x0_reg[31], x0_reg};
            vmag_reg <= vd[32] ? 33'(-vd) : 33'(vd);
        end
        if (state_reg == sslc_pkg::F_RND) d16_reg <= rnd[58:17];
        if (state_reg == sslc_pkg::F_SQ) begin
            dsq_reg <= (|d16_reg[41:32]) ? 64'hFFFF_FFFF_FFFF_FFFF
                                         : d16_reg[31:0] * d16_reg[31:0];
            vsq_reg <= vprod[63:0];
        end
    end

endmodule

// File: src/sslc_queue.sv
// ---------------------------------------------------------------------------
// sslc_queue
// Two-entry job queue between the front and the back.
// ---------------------------------------------------------------------------
module sslc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  sslc_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sslc_pkg::job_t pop_job
);

    sslc_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: src/sslc_back.sv
// ---------------------------------------------------------------------------
// sslc_back
// Per-segment cost: tau^3, two bit-serial divides, two digit-serial square
// roots, final square, running total and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sslc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  sslc_pkg::job_t pop_job,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [63:0]    m_segment_cost,
    output logic [63:0]    m_run_total,
    output logic           m_time_zero,
    output logic           m_last
);

    sslc_pkg::back_state_t state_reg, state_next;

    logic [63:0]  sd_reg, sv_reg;
    logic [23:0]  tau_reg;
    logic         ls_reg, tz_reg;
    logic [47:0]  tt_reg;
    logic [71:0]  den_reg;
    logic [127:0] num_reg;
    logic [72:0]  rem_reg;
    logic [127:0] x_reg;
    logic [65:0]  srem_reg;
    logic [63:0]  root_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  a_reg, b_reg;
    logic [31:0]  s_reg;
    logic         sat_reg;
    logic [63:0]  cost_reg, total_reg;
    logic         m_valid_reg, tz_out_reg, last_out_reg;
    logic [63:0]  seg_out_reg, tot_out_reg;

    logic [73:0]  rsh;
    logic         dge;
    logic [72:0]  rem_next;
    logic [127:0] num_next;
    logic [67:0]  st, trial;
    logic         sge;
    logic [65:0]  srem_next;
    logic [63:0]  root_next;
    logic [67:0]  sd12;
    logic [32:0]  s33;
    logic [63:0]  tot_sum;
    logic         out_fire, div_done, sqrt_done;

    // restoring divide step
    assign rsh      = {rem_reg, num_reg[127]};
    assign dge      = rsh >= {2'b0, den_reg};
    assign rem_next = dge ? 73'(rsh - {2'b0, den_reg}) : rsh[72:0];
    assign num_next = {num_reg[126:0], dge};
    // digit-serial square root step
    assign st        = {srem_reg, x_reg[127:126]};
    assign trial     = {2'b0, root_reg, 2'b01};
    assign sge       = st >= trial;
    assign srem_next = sge ? 66'(st - trial) : st[65:0];
    assign root_next = {root_reg[62:0], sge};

    assign sd12    = {sd_reg, 3'b0} + {1'b0, sd_reg, 2'b0};
    assign s33     = {1'b0, a_reg[31:0]} + {1'b0, b_reg[31:0]};
    assign tot_sum = sslc_pkg::sat_add(total_reg, cost_reg);
    assign div_done  = (cnt_reg == sslc_pkg::DivLastStep);
    assign sqrt_done = (cnt_reg == sslc_pkg::SqrtLastStep);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sslc_pkg::B_IDLE:
                if (pop_valid)
                    state_next = (pop_job.tau == '0) ? sslc_pkg::B_OUT : sslc_pkg::B_CUBE1;
            sslc_pkg::B_CUBE1: state_next = sslc_pkg::B_CUBE2;
            sslc_pkg::B_CUBE2: state_next = sslc_pkg::B_DIVA;
            sslc_pkg::B_DIVA:  if (div_done)  state_next = sslc_pkg::B_SQA;
            sslc_pkg::B_SQA:   if (sqrt_done) state_next = sslc_pkg::B_DIVB;
            sslc_pkg::B_DIVB:  if (div_done)  state_next = sslc_pkg::B_SQB;
            sslc_pkg::B_SQB:   if (sqrt_done) state_next = sslc_pkg::B_SUM;
            sslc_pkg::B_SUM:   state_next = sslc_pkg::B_SQR;
            sslc_pkg::B_SQR:   state_next = sslc_pkg::B_OUT;
            sslc_pkg::B_OUT:   if (!m_valid_reg || m_ready) state_next = sslc_pkg::B_IDLE;
            default:           state_next = sslc_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        pop_ready = 1'b0;
        out_fire  = 1'b0;
        unique case (state_reg)
            sslc_pkg::B_IDLE: pop_ready = 1'b1;
            sslc_pkg::B_OUT:  out_fire  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sslc_pkg::B_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_fire) begin
                m_valid_reg <= 1'b1;
                total_reg   <= ls_reg ? 64'd0 : tot_sum;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            sslc_pkg::B_IDLE: begin
                sd_reg   <= pop_job.sd;
                sv_reg   <= pop_job.sv;
                tau_reg  <= pop_job.tau;
                ls_reg   <= pop_job.ls;
                tz_reg   <= (pop_job.tau == '0);
                cost_reg <= 64'hFFFF_FFFF_FFFF_FFFF;
            end
            sslc_pkg::B_CUBE1: tt_reg <= tau_reg * tau_reg;
            sslc_pkg::B_CUBE2: begin
                den_reg <= tt_reg * tau_reg;
                num_reg <= {12'b0, sd12, 48'b0};
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            sslc_pkg::B_DIVA, sslc_pkg::B_DIVB: begin
                num_reg <= num_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 7'd1;
                if (div_done) begin
                    x_reg    <= num_next;
                    srem_reg <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                end
            end
            sslc_pkg::B_SQA, sslc_pkg::B_SQB: begin
                x_reg    <= {x_reg[125:0], 2'b0};
                srem_reg <= srem_next;
                root_reg <= root_next;
                cnt_reg  <= cnt_reg + 7'd1;
                if (sqrt_done) begin
                    cnt_reg <= '0;
                    if (state_reg == sslc_pkg::B_SQA) begin
                        a_reg   <= root_next;
                        num_reg <= {48'b0, sv_reg, 16'b0};
                        den_reg <= {48'b0, tau_reg};
                        rem_reg <= '0;
                    end else begin
                        b_reg <= root_next;
                    end
                end
            end
            sslc_pkg::B_SUM: begin
                s_reg   <= s33[31:0];
                sat_reg <= (|a_reg[63:32]) || (|b_reg[63:32]) || s33[32];
            end
            sslc_pkg::B_SQR:
                cost_reg <= sat_reg ? 64'hFFFF_FFFF_FFFF_FFFF : s_reg * s_reg;
            sslc_pkg::B_OUT:
                if (out_fire) begin
                    seg_out_reg  <= cost_reg;
                    tot_out_reg  <= tot_sum;
                    tz_out_reg   <= tz_reg;
                    last_out_reg <= ls_reg;
                end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_segment_cost = seg_out_reg;
    assign m_run_total    = tot_out_reg;
    assign m_time_zero    = tz_out_reg;
    assign m_last         = last_out_reg;

    `SSLC_ASSERT(a_tz_sat, aclk, aresetn, m_valid_reg && tz_out_reg |-> (seg_out_reg == '1))
    `SSLC_NEVER(a_tot_ge_seg, aclk, aresetn, m_valid_reg && (tot_out_reg < seg_out_reg))
    `SSLC_ASSERT(a_out_src, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == sslc_pkg::B_OUT))

endmodule

// File: src/spline_segment_leap_cost.sv
// ---------------------------------------------------------------------------
// spline_segment_leap_cost
// Leap cost of a cubic spline, one coordinate of one segment per request.
// ---------------------------------------------------------------------------
// Each input request carries one coordinate of a segment. The front takes
// one request at a time through multiply, round, square and accumulate
// states, forms the squared gap and squared velocity change and adds them
// to the segment sums. The coordinate flagged last (or the MAX_DIMS-th
// one) closes the segment and drops a job into a two-entry queue. The back
// turns a job into one result: tau^3, a 128-step bit-serial divide and a
// 64-step square root for the gap term, the same again for the velocity
// term, then sum and square; the shared divider and square-root unit serve
// both terms. A zero segment time skips all of that and gives a saturated
// cost. Fewer cycles per coordinate are spent than per segment, so a spline
// with many coordinates per segment amortizes the back. keep_end_vel (1
// keeps the end velocity on the final segment, 0 forces it to zero) sits at
// byte address 0 of the APB port; write it only while the block is idle.
// ---------------------------------------------------------------------------
module spline_segment_leap_cost #(
    parameter int MAX_DIMS = sslc_pkg::MaxDimsDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sslc_pkg::AddrW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_start_pos,
    input  logic signed [31:0]            s_end_pos,
    input  logic signed [31:0]            s_start_vel,
    input  logic signed [31:0]            s_end_vel,
    input  logic [sslc_pkg::TauW-1:0]     s_seg_time,
    input  logic                          s_last_coord,
    input  logic                          s_last_segment,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [63:0]                   m_segment_cost,
    output logic [63:0]                   m_run_total,
    output logic                          m_time_zero,
    output logic                          m_last
);

    logic           keep_end_vel_reg;
    logic           cfg_wr;
    logic           push_valid, push_ready, pop_valid, pop_ready;
    sslc_pkg::job_t push_job, pop_job;

    // APB: no wait states; register index is paddr[AddrW-1:2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[sslc_pkg::AddrW-1] == sslc_pkg::RegOptLastVel);
    assign prdata = (paddr[sslc_pkg::AddrW-1] == sslc_pkg::RegOptLastVel)
                    ? {31'b0, keep_end_vel_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_end_vel_reg <= 1'b0;
        end else if (cfg_wr) begin
            keep_end_vel_reg <= pwdata[0];
        end
    end

    sslc_front #(.MAX_DIMS(MAX_DIMS)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .keep_end_vel   (keep_end_vel_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_pos    (s_start_pos),
        .s_end_pos      (s_end_pos),
        .s_start_vel    (s_start_vel),
        .s_end_vel      (s_end_vel),
        .s_seg_time     (s_seg_time),
        .s_last_coord   (s_last_coord),
        .s_last_segment (s_last_segment),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_job       (push_job)
    );

    // decouples segment closing from the slow cost evaluation
    sslc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    sslc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_job        (pop_job),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_segment_cost (m_segment_cost),
        .m_run_total    (m_run_total),
        .m_time_zero    (m_time_zero),
        .m_last         (m_last)
    );

endmodule

// File: dv/sslc_checker.sv
// ---------------------------------------------------------------------------
// sslc_checker
// Scoreboard for the spline segment leap cost block: watches the APB port, the
// request and result channels, predicts each segment result, and compares.
// ---------------------------------------------------------------------------
module sslc_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sslc_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [31:0]          s_start_pos,
    input  logic signed [31:0]          s_end_pos,
    input  logic signed [31:0]          s_start_vel,
    input  logic signed [31:0]          s_end_vel,
    input  logic [sslc_pkg::TauW-1:0]   s_seg_time,
    input  logic                        s_last_coord,
    input  logic                        s_last_segment,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [63:0]                 m_segment_cost,
    input  logic [63:0]                 m_run_total,
    input  logic                        m_time_zero,
    input  logic                        m_last,
    output int                          fail_count,
    output int                          pending
);

    localparam logic [63:0] AllOnes = {64{1'b1}};

    typedef struct packed {
        logic [63:0] seg_cost;
        logic [63:0] total;
        logic        tzero;
        logic        last;
    } seg_result_t;

    seg_result_t expected_segments[$];

    logic        use_end_vel;
    logic [63:0] gap_sq_acc;
    logic [63:0] dvel_sq_acc;
    logic [63:0] spline_total;
    int          coords_taken;

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? AllOnes : s[63:0];
    endfunction

    function automatic logic [63:0] floor_root(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] c2;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            c2 = {64'd0, c} * {64'd0, c};
            if (x >= c2) r = c;
        end
        return r;
    endfunction

    // cost from the current sums; tau assumed nonzero
    function automatic logic [63:0] leap_cost(input logic [23:0] tau);
        logic [127:0] num;
        logic [127:0] den;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  s;
        num = ({64'd0, gap_sq_acc} * 128'd12) << 48;
        den = {104'd0, tau} * {104'd0, tau} * {104'd0, tau};
        a = floor_root(num / den);
        num = {64'd0, dvel_sq_acc} << 16;
        b = floor_root(num / {104'd0, tau});
        if (a >= 64'h1_0000_0000 || b >= 64'h1_0000_0000) return AllOnes;
        s = a + b;
        if (s >= 64'h1_0000_0000) return AllOnes;
        return s * s;
    endfunction

    task automatic take_coordinate();
        longint      x0, x1, v0, v1, gap, dv;
        logic [63:0] mag, g16, sq;
        seg_result_t r;
        x0 = longint'(s_start_pos);
        x1 = longint'(s_end_pos);
        v0 = longint'(s_start_vel);
        v1 = longint'(s_end_vel);
        if (s_last_segment && !use_end_vel) v1 = 0;
        gap = (x1 - x0) * 131072 - longint'({40'd0, s_seg_time}) * (v0 + v1);
        mag = (gap < 0) ? 64'(-gap) : 64'(gap);
        g16 = (mag + 64'd65536) >> 17;
        sq = (g16 >= 64'h1_0000_0000) ? AllOnes : g16 * g16;
        gap_sq_acc = add_sat(gap_sq_acc, sq);
        dv = v1 - v0;
        mag = (dv < 0) ? 64'(-dv) : 64'(dv);
        dvel_sq_acc = add_sat(dvel_sq_acc, mag * mag);   // square wraps at 64 bits
        coords_taken++;
        if (!s_last_coord && coords_taken < sslc_pkg::MaxDimsDef) return;
        r.tzero = (s_seg_time == '0);
        r.seg_cost = r.tzero ? AllOnes : leap_cost(s_seg_time);
        spline_total = add_sat(spline_total, r.seg_cost);
        r.total = spline_total;
        r.last = s_last_segment;
        expected_segments.push_back(r);
        gap_sq_acc = '0;
        dvel_sq_acc = '0;
        coords_taken = 0;
        if (s_last_segment) spline_total = '0;
    endtask

    task automatic compare_result();
        seg_result_t e;
        if (expected_segments.size() == 0) begin
            $display("%0t: unexpected result cost=%h total=%h", $time, m_segment_cost,
                     m_run_total);
            fail_count++;
            return;
        end
        e = expected_segments.pop_front();
        if (m_segment_cost !== e.seg_cost) begin
            $display("%0t: segment_cost expected %h actual %h", $time, e.seg_cost,
                     m_segment_cost);
            fail_count++;
        end
        if (m_run_total !== e.total) begin
            $display("%0t: run_total expected %h actual %h", $time, e.total, m_run_total);
            fail_count++;
        end
        if (m_time_zero !== e.tzero) begin
            $display("%0t: time_zero expected %b actual %b", $time, e.tzero, m_time_zero);
            fail_count++;
        end
        if (m_last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, m_last);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            use_end_vel <= 1'b0;
            fail_count = 0;
            gap_sq_acc = '0;
            dvel_sq_acc = '0;
            spline_total = '0;
            coords_taken = 0;
            expected_segments.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[sslc_pkg::AddrW-1:2] == sslc_pkg::RegOptLastVel)
                use_end_vel <= pwdata[0];
            if (m_valid && m_ready) compare_result();
            if (s_valid && s_ready) take_coordinate();
        end
        pending = expected_segments.size();
    end

endmodule

// File: dv/tb_spline_segment_leap_cost.sv
// ---------------------------------------------------------------------------
// tb_spline_segment_leap_cost
// Directed and random requests into the leap cost block, checked by a
// side-by-side scoreboard, across both settings of keep_end_vel.
// ---------------------------------------------------------------------------
module tb_spline_segment_leap_cost;

    localparam int CycleLimit = 4_000_000;
    localparam int TargetItems = 1800;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [sslc_pkg::AddrW-1:0]    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [31:0]            s_start_pos = '0;
    logic signed [31:0]            s_end_pos = '0;
    logic signed [31:0]            s_start_vel = '0;
    logic signed [31:0]            s_end_vel = '0;
    logic [sslc_pkg::TauW-1:0]     s_seg_time = '0;
    logic                          s_last_coord = 1'b0;
    logic                          s_last_segment = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [63:0]                   m_segment_cost;
    logic [63:0]                   m_run_total;
    logic                          m_time_zero;
    logic                          m_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    bit gaps_on = 1'b1;     // cleared for the final stretch
    int stall_left = 0;

    always #2 aclk = ~aclk;

    spline_segment_leap_cost uut (.*);

    sslc_checker scoreboard (.*);

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver backpressure: random stall bursts while gaps are on
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one coordinate request; valid stays up across back-to-back requests
    task automatic send_coord(input logic [31:0] x0, input logic [31:0] x1,
                              input logic [31:0] v0, input logic [31:0] v1,
                              input logic [23:0] tau, input logic lc, input logic ls);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_start_pos <= x0;
        s_end_pos <= x1;
        s_start_vel <= v0;
        s_end_vel <= v1;
        s_seg_time <= tau;
        s_last_coord <= lc;
        s_last_segment <= ls;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // drain: nothing in flight, then margin for a segment still being summed
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_opt(input logic v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sslc_pkg::RegOptLastVel, 2'b00};
        pwdata <= {31'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic logic [23:0] pick_tau();
        case ($urandom_range(0, 19))
            0:       return 24'd0;
            1:       return 24'hFF_FFFF;
            2, 3:    return 24'($urandom_range(1, 255));
            4, 5, 6: return 24'($urandom());
            default: return 24'($urandom_range(1 << 13, 1 << 19));
        endcase
    endfunction

    // a segment of random shape; occasionally runs past MAX_DIMS untagged
    task automatic random_segment();
        int          n;
        bit          overrun;
        logic        ls;
        logic [23:0] tau;
        overrun = ($urandom_range(0, 9) == 0);
        n = overrun ? $urandom_range(sslc_pkg::MaxDimsDef + 1, sslc_pkg::MaxDimsDef + 4)
                    : $urandom_range(1, sslc_pkg::MaxDimsDef);
        ls = ($urandom_range(0, 3) == 0);
        tau = pick_tau();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) tau = pick_tau();   // per-coordinate time
            send_coord(pick_word(), pick_word(), pick_word(), pick_word(), tau,
                       (!overrun && i == n - 1) || $urandom_range(0, 40) == 0,
                       ($urandom_range(0, 20) == 0) ? !ls : ls);
        end
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            random_segment();
            if ($urandom_range(0, 80) == 0) wait_idle();   // sender holds off
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_opt(1'b0);

        // zero displacement and velocity: zero cost
        send_coord(0, 0, 0, 0, 24'h01_0000, 1'b1, 1'b0);
        // unit move, two coordinates, final segment with end velocity forced to zero
        send_coord(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'h01_0000, 1'b0, 1'b1);
        send_coord(32'h0001_0000, 0, 0, 32'hFFFF_0000, 24'h01_0000, 1'b1, 1'b1);
        // zero segment time
        send_coord(32'h0003_0000, 32'h0005_0000, 0, 0, 24'd0, 1'b1, 1'b0);
        // extremes with the smallest time: saturating sums and cost
        send_coord(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'd1,
                   1'b0, 1'b0);
        send_coord(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1,
                   1'b1, 1'b0);
        // largest time
        send_coord(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF,
                   1'b1, 1'b1);
        // MAX_DIMS coordinates without a last tag close on their own
        for (int i = 0; i < sslc_pkg::MaxDimsDef; i++)
            send_coord(32'(i << 16), 32'((i + 1) << 16), 32'h0000_8000, 32'hFFFF_8000,
                       24'(24'h00_8000 + (i << 12)), 1'b0, 1'b0);
        // differing times within one segment
        send_coord(0, 32'h0002_0000, 0, 32'h0001_0000, 24'h02_0000, 1'b0, 1'b0);
        send_coord(0, 32'h0002_0000, 0, 32'h0001_0000, 24'h00_4000, 1'b1, 1'b1);
        wait_idle();

        write_opt(1'b1);
        // same final segment with end velocity kept
        send_coord(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'h01_0000, 1'b0, 1'b1);
        send_coord(32'h0001_0000, 0, 0, 32'hFFFF_0000, 24'h01_0000, 1'b1, 1'b1);
        random_phase(600);
        wait_idle();

        write_opt(1'b0);
        random_phase(600);
        wait_idle();

        write_opt(1'b1);
        random_phase(TargetItems / 6);
        gaps_on = 1'b0;
        random_phase(TargetItems / 6);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: spline_segment_leap_cost.f
+incdir+src
src/sslc_pkg.sv
src/sslc_front.sv
src/sslc_queue.sv
src/sslc_back.sv
src/spline_segment_leap_cost.sv
dv/sslc_checker.sv
dv/tb_spline_segment_leap_cost.sv
